@@ rtl/core/policy_queue_port_defines.svh @@
// Assertion macros for the policy queue port.
`ifndef POLICY_QUEUE_PORT_DEFINES_SVH
`define POLICY_QUEUE_PORT_DEFINES_SVH

`ifndef SYNTHESIS

`define PQP_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define PQP_ASSERT(lbl, prop, msg) \
  `PQP_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`else

`define PQP_ASSERT_CLK(lbl, clk, rstn, prop, msg)

`define PQP_ASSERT(lbl, prop, msg)

`endif

`endif

@@ rtl/core/pqp_pkg.sv @@
`timescale 1ns / 1ps

package pqp_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int LIMIT_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int USER_IN_W  = 3;

  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_PEEK  = 2'd1,
    MODE_POP   = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    POL_UFIFO = 2'd0,
    POL_BFIFO = 2'd1,
    POL_LIFO  = 2'd2,
    POL_LAST  = 2'd3
  } policy_e;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd1;

  localparam policy_e             POLICY_RESET = POL_BFIFO;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 5'd16;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic shift;   // take the word of the upper neighbor
    logic wr_en;   // selected cell loads the write word
  } pqp_ctl_t;

endpackage

@@ rtl/core/pqp_cell.sv @@
`timescale 1ns / 1ps

module pqp_cell import pqp_pkg::*; #(
  parameter int DW = DATA_WIDTH_DEF
) (
  input  logic          clk_i,
  input  pqp_ctl_t      ctl_i,
  input  logic          wr_sel_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic [DW-1:0] up_data_i,
  output logic [DW-1:0] data_o
);

  logic [DW-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctl_i.wr_en && wr_sel_i) begin
      data_d = wr_data_i;
    end else if (ctl_i.shift) begin
      data_d = up_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ rtl/core/pqp_chain.sv @@
`timescale 1ns / 1ps

module pqp_chain import pqp_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int DW    = DATA_WIDTH_DEF,
  localparam int IW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  pqp_ctl_t      ctl_i,
  input  logic [IW-1:0] wr_idx_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic [IW-1:0] rd_idx_i,
  output logic [DW-1:0] rd_data_o
);

  // cell 0 holds the oldest word
  logic [DW-1:0] cell_data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DW-1:0] up_data;
    if (i == DEPTH - 1) begin : g_top
      assign up_data = '0;
    end else begin : g_mid
      assign up_data = cell_data[i+1];
    end

    pqp_cell #(
      .DW(DW)
    ) u_cell (
      .clk_i    (clk_i),
      .ctl_i    (ctl_i),
      .wr_sel_i (wr_idx_i == IW'(i)),
      .wr_data_i(wr_data_i),
      .up_data_i(up_data),
      .data_o   (cell_data[i])
    );
  end

  always_comb begin
    rd_data_o = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (rd_idx_i == IW'(i)) begin
        rd_data_o = rd_data_o | cell_data[i];
      end
    end
  end

endmodule

@@ rtl/core/policy_queue_port.sv @@
`timescale 1ns / 1ps
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tdata payload, tuser mode + payload_valid
// m_axis    out  m_axis_tvalid/tready       tdata read_data + fill_count, tuser status
// cfg       in   cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
// One word per cycle unless stalled: each command is decoded and applied to the cell
// chain in the cycle it is accepted, and its result lands in the output register.
// A stalled output register holds s_axis_tready low until it is taken.
// rst_ni clears the count, the policy (bounded FIFO) and the limit (16).
// Config writes are always taken; cfg_ready_o is tied high.

`include "policy_queue_port_defines.svh"

module policy_queue_port import pqp_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int CW        = $clog2(DEPTH + 1),
  localparam int IDW       = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int ODW       = ((DATA_WIDTH + CW + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IDW-1:0]        s_axis_tdata,  // payload
  input  logic [USER_IN_W-1:0]  s_axis_tuser,  // mode [1:0], payload_valid [2]

  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [ODW-1:0]        m_axis_tdata,  // read_data, fill_count
  output logic [1:0]            m_axis_tuser,  // status

  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int IW = $clog2(DEPTH);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  policy_e               policy_q;
  logic [LIMIT_W-1:0]    limit_q;
  logic [CW-1:0]         count_q, count_d;

  logic                  out_valid_q;
  status_e               out_status_q, status_d;
  logic [DATA_WIDTH-1:0] out_data_q, rd_d;
  logic [CW-1:0]         out_count_q;

  logic                  in_acc;
  mode_e                 mode;
  logic                  pay_valid;
  logic [DATA_WIDTH-1:0] payload;
  logic [LW-1:0]         lim_eff, cnt_ext;
  logic [CW-1:0]         cnt_m1;

  pqp_ctl_t              ctl;
  logic [IW-1:0]         wr_idx, rd_idx;
  logic [DATA_WIDTH-1:0] rd_word;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign mode      = mode_e'(s_axis_tuser[1:0]);
  assign pay_valid = s_axis_tuser[2];
  assign payload   = s_axis_tdata[DATA_WIDTH-1:0];

  assign cnt_ext = LW'(count_q);
  assign cnt_m1  = count_q - CW'(1);

  always_comb begin
    lim_eff = LW'(limit_q);
    if (limit_q == '0) begin
      lim_eff = LW'(1);
    end else if (LW'(limit_q) > LW'(DEPTH)) begin
      lim_eff = LW'(DEPTH);
    end
  end

  assign rd_idx = (policy_q == POL_LIFO) ? cnt_m1[IW-1:0] : '0;

  always_comb begin
    count_d   = count_q;
    status_d  = ST_OK;
    rd_d      = '0;
    ctl.shift = 1'b0;
    ctl.wr_en = 1'b0;
    wr_idx    = count_q[IW-1:0];
    case (mode)
      MODE_PUSH: begin
        if (!pay_valid) begin
          status_d = ST_BAD;
        end else begin
          case (policy_q)
            POL_BFIFO: begin
              ctl.wr_en = 1'b1;
              if (cnt_ext >= lim_eff) begin
                ctl.shift = 1'b1;
                wr_idx    = cnt_m1[IW-1:0];
              end else begin
                count_d = count_q + CW'(1);
              end
            end
            POL_LAST: begin
              ctl.wr_en = 1'b1;
              wr_idx    = '0;
              count_d   = CW'(1);
            end
            default: begin
              if (count_q == CW'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                ctl.wr_en = 1'b1;
                count_d   = count_q + CW'(1);
              end
            end
          endcase
        end
      end
      MODE_PEEK, MODE_POP: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          rd_d = rd_word;
          if (mode == MODE_POP) begin
            count_d   = cnt_m1;
            ctl.shift = (policy_q != POL_LIFO);
          end
        end
      end
      MODE_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
    if (!in_acc) begin
      count_d   = count_q;
      ctl.shift = 1'b0;
      ctl.wr_en = 1'b0;
    end
  end

  pqp_chain #(
    .DEPTH(DEPTH),
    .DW   (DATA_WIDTH)
  ) u_chain (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .wr_idx_i (wr_idx),
    .wr_data_i(payload),
    .rd_idx_i (rd_idx),
    .rd_data_o(rd_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q    <= POLICY_RESET;
      limit_q     <= LIMIT_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_POLICY) begin
          policy_q <= policy_e'(cfg_data_i[1:0]);
        end else if (cfg_index_i == CFG_LIMIT) begin
          limit_q <= cfg_data_i[LIMIT_W-1:0];
        end
      end
      count_q <= count_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_status_q <= status_d;
      out_data_q   <= rd_d;
      out_count_q  <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = ODW'({out_count_q, out_data_q});

  `PQP_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "fill count above depth")
  `PQP_ASSERT(a_clear_empties, (in_acc && mode == MODE_CLEAR) |=> (count_q == '0), "clear left words")
  `PQP_ASSERT(a_last_one, (in_acc && mode == MODE_PUSH && pay_valid && policy_q == POL_LAST) |=> (count_q == CW'(1)), "keep-last count not one")
  `PQP_ASSERT(a_result_shown, in_acc |=> m_axis_tvalid, "accepted word gave no result")

endmodule

@@ test/tb_policy_queue_port.sv @@
`timescale 1ns / 1ps

module tb_policy_queue_port;
  import pqp_pkg::*;

  localparam int DW             = 32;
  localparam int CW             = 5;
  localparam int SLOTS          = 16;
  localparam int RANDOM_ITEMS   = 1250;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DUE_SLOTS      = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_3 = 2'd3;

  typedef struct packed {
    status_e         status;
    logic [DW-1:0]   read_data;
    logic [CW-1:0]   fill_count;
  } queue_result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata  = '0;  // payload
  logic [USER_IN_W-1:0]  s_axis_tuser  = '0;  // mode [1:0], payload_valid [2]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [39:0]           m_axis_tdata;        // read_data [31:0], fill_count [36:32]
  logic [1:0]            m_axis_tuser;        // status
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // queue mirror
  logic [DW-1:0]  model_words [SLOTS];
  logic [3:0]     model_head   = '0;
  logic [CW-1:0]  model_count  = '0;
  policy_e        model_policy = POLICY_RESET;
  logic [CW-1:0]  model_limit  = LIMIT_RESET;

  // expected words in flight, kept in a small ring
  queue_result_t  due_results [DUE_SLOTS];
  int             due_wr       = 0;
  int             due_rd       = 0;
  int             fail_count   = 0;
  bit             calm         = 1'b0;
  bit             hold_request = 1'b0;

  policy_queue_port u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic int due_level();
    return due_wr - due_rd;
  endfunction

  function automatic void expect_put(queue_result_t r);
    due_results[due_wr % DUE_SLOTS] = r;
    due_wr++;
  endfunction

  function automatic queue_result_t expect_take();
    queue_result_t r;
    r = due_results[due_rd % DUE_SLOTS];
    due_rd++;
    return r;
  endfunction

  function automatic void append_word(logic [DW-1:0] word);
    logic [3:0] slot;
    slot = model_head + model_count[3:0];
    model_words[slot] = word;
    model_count++;
  endfunction

  function automatic queue_result_t apply_command(mode_e cmd, logic [DW-1:0] word,
                                                  logic word_ok);
    queue_result_t r;
    logic [CW-1:0] eff_limit;
    logic [3:0]    slot;
    r.status    = ST_OK;
    r.read_data = '0;
    case (cmd)
      MODE_PUSH: begin
        if (!word_ok) begin
          r.status = ST_BAD;
        end else begin
          case (model_policy)
            POL_BFIFO: begin
              eff_limit = model_limit;
              if (eff_limit < 1) eff_limit = 1;
              if (eff_limit > SLOTS) eff_limit = SLOTS;
              if (model_count >= eff_limit) begin
                model_head++;
                model_count--;
              end
              append_word(word);
            end
            POL_LAST: begin
              model_count = '0;
              model_head  = '0;
              append_word(word);
            end
            default: begin
              if (model_count >= SLOTS) r.status = ST_FULL;
              else append_word(word);
            end
          endcase
        end
      end
      MODE_PEEK, MODE_POP: begin
        if (model_count == 0) begin
          r.status = ST_EMPTY;
        end else if (model_policy == POL_LIFO) begin
          slot = model_head + 4'(model_count - 1);
          r.read_data = model_words[slot];
          if (cmd == MODE_POP) model_count--;
        end else begin
          r.read_data = model_words[model_head];
          if (cmd == MODE_POP) begin
            model_head++;
            model_count--;
          end
        end
      end
      default: begin
        model_count = '0;
        model_head  = '0;
      end
    endcase
    r.fill_count = model_count;
    return r;
  endfunction

  function automatic void note_mismatch(string what, logic [DW-1:0] want, logic [DW-1:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch %0s: expected %h, got %h at %0t", what, want, got, $realtime);
  endfunction

  task automatic send_word(mode_e cmd, logic [DW-1:0] word, logic word_ok);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= {word_ok, cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expect_put(apply_command(cmd, word, word_ok));
  endtask

  task automatic drain_queue();
    s_axis_tvalid <= 1'b0;
    while (due_level() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    drain_queue();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_POLICY) model_policy = policy_e'(value[1:0]);
    else if (idx == CFG_LIMIT) model_limit = value;
  endtask

  task automatic test_empty_reads();
    send_word(MODE_PEEK, 32'h0000_0000, 1'b1);
    send_word(MODE_POP, 32'hFFFF_FFFF, 1'b0);
  endtask

  task automatic test_word_extremes();
    send_word(MODE_PUSH, 32'h0000_0000, 1'b1);
    send_word(MODE_PUSH, 32'hFFFF_FFFF, 1'b1);
    send_word(MODE_PUSH, 32'hA5A5_5A5A, 1'b0);
    send_word(MODE_PEEK, 32'h0, 1'b0);
    send_word(MODE_POP, 32'h0, 1'b1);
    send_word(MODE_POP, 32'h0, 1'b1);
    send_word(MODE_POP, 32'h0, 1'b1);
    send_word(MODE_CLEAR, 32'h5A5A_A5A5, 1'b1);
  endtask

  task automatic test_bounded_drop();
    cfg_write(CFG_LIMIT, 5'd2);
    send_word(MODE_PUSH, 32'h1111_0001, 1'b1);
    send_word(MODE_PUSH, 32'h1111_0002, 1'b1);
    send_word(MODE_PUSH, 32'h1111_0003, 1'b1);
    send_word(MODE_PEEK, 32'h0, 1'b1);
    cfg_write(CFG_LIMIT, 5'd0);
    send_word(MODE_PUSH, 32'h1111_0004, 1'b1);
    send_word(MODE_POP, 32'h0, 1'b1);
    send_word(MODE_CLEAR, 32'h0, 1'b0);
  endtask

  task automatic test_lifo_full();
    int i;
    cfg_write(CFG_POLICY, 5'(POL_LIFO));
    for (i = 0; i < SLOTS; i++) send_word(MODE_PUSH, 32'h2222_0000 + i, 1'b1);
    send_word(MODE_PUSH, 32'h2222_FFFF, 1'b1);
    send_word(MODE_POP, 32'h0, 1'b1);
    // stored words survive the policy switch; limit above depth saturates
    cfg_write(CFG_POLICY, 5'(POL_BFIFO));
    cfg_write(CFG_LIMIT, 5'd31);
    cfg_write(CFG_UNUSED_2, 5'd31);
    cfg_write(CFG_UNUSED_3, 5'd0);
    send_word(MODE_PUSH, 32'h3333_0001, 1'b1);
    send_word(MODE_PUSH, 32'h3333_0002, 1'b1);
    send_word(MODE_PEEK, 32'h0, 1'b1);
    send_word(MODE_CLEAR, 32'h0, 1'b1);
  endtask

  task automatic test_keep_last();
    cfg_write(CFG_POLICY, 5'(POL_LAST));
    send_word(MODE_PUSH, 32'h4444_0001, 1'b1);
    send_word(MODE_PUSH, 32'h4444_0002, 1'b1);
    send_word(MODE_PEEK, 32'h0, 1'b1);
    send_word(MODE_POP, 32'h0, 1'b1);
    send_word(MODE_POP, 32'h0, 1'b1);
  endtask

  task automatic test_output_stall();
    int i;
    cfg_write(CFG_POLICY, 5'(POL_UFIFO));
    calm = 1'b1;
    hold_request = 1'b1;
    for (i = 0; i < 24; i++)
      send_word((i % 3 == 2) ? MODE_POP : MODE_PUSH, 32'hC0DE_0000 + i, 1'b1);
    calm = 1'b0;
    drain_queue();
  endtask

  task automatic test_random_mix();
    int            sent;
    int            span;
    int            push_pct;
    int            roll;
    logic [4:0]    lim_val;
    logic [DW-1:0] word;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      cfg_write(CFG_POLICY, 5'($urandom_range(0, 31)));
      case ($urandom_range(0, 7))
        0:       lim_val = 5'd0;
        1:       lim_val = 5'd1;
        2:       lim_val = 5'd16;
        3:       lim_val = 5'd17;
        4:       lim_val = 5'd31;
        default: lim_val = 5'($urandom_range(1, 16));
      endcase
      cfg_write(CFG_LIMIT, lim_val);
      if ($urandom_range(0, 3) == 0)
        cfg_write($urandom_range(0, 1) ? CFG_UNUSED_2 : CFG_UNUSED_3, 5'($urandom));
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0:       push_pct = 75;
        1:       push_pct = 50;
        default: push_pct = 30;
      endcase
      span = $urandom_range(20, 80);
      repeat (span) begin
        roll = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
          0:       word = '0;
          1:       word = '1;
          default: word = $urandom();
        endcase
        if (roll < push_pct) send_word(MODE_PUSH, word, $urandom_range(0, 15) != 0);
        else if (roll < push_pct + 3) send_word(MODE_CLEAR, word, 1'($urandom));
        else if (roll % 3 == 0) send_word(MODE_PEEK, word, 1'($urandom));
        else send_word(MODE_POP, word, 1'($urandom));
        sent++;
      end
    end
    calm = 1'b0;
  endtask

  // result side: random stalls, one long hold on request, checks every word
  initial begin
    int            stall_left;
    int            hold_left;
    queue_result_t want;
    stall_left = draw_gap();
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (due_level() == 0) begin
          note_mismatch("unexpected word", '0, m_axis_tdata[31:0]);
        end else begin
          want = expect_take();
          if (m_axis_tuser != want.status)
            note_mismatch("status", 32'(want.status), 32'(m_axis_tuser));
          if (m_axis_tdata[31:0] != want.read_data)
            note_mismatch("read_data", want.read_data, m_axis_tdata[31:0]);
          if (m_axis_tdata[36:32] != want.fill_count)
            note_mismatch("fill_count", 32'(want.fill_count), 32'(m_axis_tdata[36:32]));
        end
        stall_left = draw_gap();
      end
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
          || (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_reads();
    test_word_extremes();
    test_bounded_drop();
    test_lifo_full();
    test_keep_last();
    test_output_stall();
    test_random_mix();
    drain_queue();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && due_level() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ policy_queue_port.f @@
+incdir+rtl/core
rtl/core/pqp_pkg.sv
rtl/core/pqp_cell.sv
rtl/core/pqp_chain.sv
rtl/core/policy_queue_port.sv
test/tb_policy_queue_port.sv
